>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk, disabled while rst_n is low.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion sampled on clk, active during reset as well.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/pss_pkg.sv
// Package for the process slot scheduler: result, request and mode codes and controller/datapath structs.
package pss_pkg;

    localparam logic [1:0] ST_RAN    = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_ACCEPT = 2'd2;
    localparam logic [1:0] ST_REJECT = 2'd3;

    localparam logic REQ_ARRIVE = 1'b0;
    localparam logic REQ_SLOT   = 1'b1;

    localparam logic MODE_RR  = 1'b0;
    localparam logic MODE_PRI = 1'b1;

    typedef struct packed {
        logic load;
        logic arrive;
        logic emit_idle;
        logic rr_init;
        logic rr_step;
        logic pri_init;
        logic pri_load_cur;
        logic pri_step;
        logic run;
    } t_dp_cmd;

    typedef struct packed {
        logic is_slot;
        logic mode;
        logic empty;
        logic rr_hit;
        logic rr_last;
        logic scan_done;
        logic sel_vld;
    } t_dp_stat;

endpackage

>>> hdl/pss_ctrl.sv
// Scheduler controller: sequences arrivals, round-robin and priority scans.
module pss_ctrl import pss_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    output logic     o_busy,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_RR       = 3'd2;
    localparam logic [2:0] S_PCUR     = 3'd3;
    localparam logic [2:0] S_PSCAN    = 3'd4;
    localparam logic [2:0] S_RD       = 3'd5;
    localparam logic [2:0] S_RUN      = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_stat.is_slot) begin
                    o_cmd.arrive = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_stat.empty) begin
                    o_cmd.emit_idle = 1'b1;
                    n_state         = S_IDLE;
                end else if (i_stat.mode == MODE_PRI) begin
                    o_cmd.pri_init = 1'b1;
                    n_state        = S_PCUR;
                end else begin
                    o_cmd.rr_init = 1'b1;
                    n_state       = S_RR;
                end
            end
            S_RR: begin
                o_cmd.rr_step = 1'b1;
                if (i_stat.rr_hit) begin
                    n_state = S_RD;
                end else if (i_stat.rr_last) begin
                    o_cmd.emit_idle = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_PCUR: begin
                o_cmd.pri_load_cur = 1'b1;
                n_state            = S_PSCAN;
            end
            S_PSCAN: begin
                if (i_stat.scan_done) begin
                    if (i_stat.sel_vld) begin
                        n_state = S_RD;
                    end else begin
                        o_cmd.emit_idle = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_cmd.pri_step = 1'b1;
                end
            end
            S_RD: begin
                n_state = S_RUN;
            end
            S_RUN: begin
                o_cmd.run = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> hdl/pss_dp.sv
// Scheduler datapath: process table memories, finished flags, scan pointers, result registers.
module pss_dp import pss_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_stat   o_stat,
    input  logic       i_req_type,
    input  logic [7:0] i_proc_id,
    input  logic [3:0] i_proc_priority,
    input  logic [7:0] i_burst_len,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    output logic       o_result_valid,
    output logic [1:0] o_status,
    output logic [7:0] o_run_pid,
    output logic       o_finished,
    output logic [4:0] o_completed_total
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = IW + 1;

    logic [7:0] mem_pid    [ENTRIES];
    logic [3:0] mem_pri    [ENTRIES];
    logic [7:0] mem_burst  [ENTRIES];
    logic [7:0] mem_served [ENTRIES];

    logic [7:0] r_rd_pid;
    logic [3:0] r_rd_pri;
    logic [7:0] r_rd_burst;
    logic [7:0] r_rd_served;

    logic [CW-1:0]      r_count;
    logic [IW-1:0]      r_cur;
    logic [IW-1:0]      r_ptr;
    logic [IW-1:0]      r_sel;
    logic [IW-1:0]      r_chk;
    logic [CW-1:0]      r_idx;
    logic               r_sel_vld;
    logic               r_chk_vld;
    logic [3:0]         r_best;
    logic [4:0]         r_done_cnt;
    logic [4:0]         n_done_cnt;
    logic [ENTRIES-1:0] r_fin;
    logic               r_mode;

    logic       r_type;
    logic [7:0] r_pid_in;
    logic [3:0] r_pri_in;
    logic [7:0] r_burst_in;

    logic       r_out_valid;
    logic [1:0] r_out_status;
    logic [7:0] r_out_pid;
    logic       r_out_fin;
    logic [4:0] r_out_total;

    logic [CW-1:0] cur_inc;
    logic [CW-1:0] ptr_inc;
    logic [IW-1:0] cur_next;
    logic [IW-1:0] ptr_next;
    logic          arr_ok;
    logic [IW-1:0] wr_idx;
    logic [IW-1:0] raddr;
    logic [7:0]    served_inc;
    logic          fin_now;
    logic          pri_take;

    assign cur_inc    = {1'b0, r_cur} + CW'(1);
    assign ptr_inc    = {1'b0, r_ptr} + CW'(1);
    assign cur_next   = (cur_inc == r_count) ? '0 : cur_inc[IW-1:0];
    assign ptr_next   = (ptr_inc == r_count) ? '0 : ptr_inc[IW-1:0];
    assign arr_ok     = (r_count < CW'(ENTRIES)) && (r_burst_in != 8'd0);
    assign wr_idx     = r_count[IW-1:0];
    assign served_inc = r_rd_served + 8'd1;
    assign fin_now    = (served_inc == r_rd_burst);
    assign pri_take   = r_chk_vld && !r_fin[r_chk] && (!r_sel_vld || (r_best < r_rd_pri));
    assign n_done_cnt = fin_now ? (r_done_cnt + 5'd1) : r_done_cnt;

    always_comb begin
        if (i_cmd.pri_init) begin
            raddr = r_cur;
        end else if (i_cmd.pri_step) begin
            raddr = r_idx[IW-1:0];
        end else begin
            raddr = r_sel;
        end
    end

    // table memories: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.arrive && arr_ok) begin
            mem_pid[wr_idx]   <= r_pid_in;
            mem_pri[wr_idx]   <= r_pri_in;
            mem_burst[wr_idx] <= r_burst_in;
        end
        if (i_cmd.arrive && arr_ok) begin
            mem_served[wr_idx] <= 8'd0;
        end else if (i_cmd.run) begin
            mem_served[r_sel] <= served_inc;
        end
        r_rd_pid    <= mem_pid[raddr];
        r_rd_pri    <= mem_pri[raddr];
        r_rd_burst  <= mem_burst[raddr];
        r_rd_served <= mem_served[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type     <= i_req_type;
            r_pid_in   <= i_proc_id;
            r_pri_in   <= i_proc_priority;
            r_burst_in <= i_burst_len;
        end
        if (i_cmd.rr_init) begin
            r_ptr <= cur_next;
        end else if (i_cmd.rr_step && r_fin[r_ptr]) begin
            r_ptr <= ptr_next;
        end
        if (i_cmd.rr_step && !r_fin[r_ptr]) begin
            r_sel <= r_ptr;
        end else if (i_cmd.pri_init) begin
            r_sel <= r_cur;
        end else if (i_cmd.pri_step && pri_take) begin
            r_sel <= r_chk;
        end
        if (i_cmd.rr_init || i_cmd.pri_init) begin
            r_idx <= '0;
        end else if (i_cmd.rr_step || (i_cmd.pri_step && (r_idx != r_count))) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.pri_step) begin
            r_chk <= r_idx[IW-1:0];
        end
        if (i_cmd.pri_load_cur) begin
            r_best <= r_rd_pri;
        end else if (i_cmd.pri_step && pri_take) begin
            r_best <= r_rd_pri;
        end
        if (i_cmd.arrive) begin
            r_out_status <= arr_ok ? ST_ACCEPT : ST_REJECT;
            r_out_pid    <= 8'd0;
            r_out_fin    <= 1'b0;
            r_out_total  <= r_done_cnt;
        end else if (i_cmd.emit_idle) begin
            r_out_status <= ST_IDLE;
            r_out_pid    <= 8'd0;
            r_out_fin    <= 1'b0;
            r_out_total  <= r_done_cnt;
        end else if (i_cmd.run) begin
            r_out_status <= ST_RAN;
            r_out_pid    <= r_rd_pid;
            r_out_fin    <= fin_now;
            r_out_total  <= n_done_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cur       <= '0;
            r_done_cnt  <= '0;
            r_fin       <= '0;
            r_mode      <= MODE_RR;
            r_sel_vld   <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.arrive || i_cmd.emit_idle || i_cmd.run;
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (i_cmd.arrive && arr_ok) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.pri_init) begin
                r_sel_vld <= !r_fin[r_cur];
                r_chk_vld <= 1'b0;
            end else if (i_cmd.pri_step) begin
                if (pri_take) begin
                    r_sel_vld <= 1'b1;
                end
                r_chk_vld <= (r_idx != r_count);
            end
            if (i_cmd.run) begin
                r_cur      <= r_sel;
                r_done_cnt <= n_done_cnt;
                if (fin_now) begin
                    r_fin[r_sel] <= 1'b1;
                end
            end
        end
    end

    assign o_stat.is_slot   = (r_type == REQ_SLOT);
    assign o_stat.mode      = r_mode;
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.rr_hit    = !r_fin[r_ptr];
    assign o_stat.rr_last   = ((r_idx + CW'(1)) == r_count);
    assign o_stat.scan_done = (r_idx == r_count) && !r_chk_vld;
    assign o_stat.sel_vld   = r_sel_vld;

    assign o_result_valid    = r_out_valid;
    assign o_status          = r_out_status;
    assign o_run_pid         = r_out_pid;
    assign o_finished        = r_out_fin;
    assign o_completed_total = r_out_total;

endmodule

>>> hdl/process_slot_scheduler.sv
// Process slot scheduler top level: controller, datapath and configuration port.
// One transaction at a time, no output stall. Round-robin slot: one finished flag checked per cycle.
// Priority slot: one priority read from the table per cycle. o_busy drops in the cycle o_result_valid rises.
// i_rst_n (synchronous) empties the table, clears finished flags, the current pointer, done counter and policy_mode.
module process_slot_scheduler import pss_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic       i_req_type,
    input  logic [7:0] i_proc_id,
    input  logic [3:0] i_proc_priority,
    input  logic [7:0] i_burst_len,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    output logic       o_result_valid,
    output logic [1:0] o_status,
    output logic [7:0] o_run_pid,
    output logic       o_finished,
    output logic [4:0] o_completed_total
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    pss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pss_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_req_type        (i_req_type),
        .i_proc_id         (i_proc_id),
        .i_proc_priority   (i_proc_priority),
        .i_burst_len       (i_burst_len),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_result_valid    (o_result_valid),
        .o_status          (o_status),
        .o_run_pid         (o_run_pid),
        .o_finished        (o_finished),
        .o_completed_total (o_completed_total)
    );

endmodule

>>> hdl/pss_chk.sv
// Port-level checker for the process slot scheduler, bound to the top level.
`include "assert_macros.svh"

module pss_chk import pss_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_result_valid,
    input logic [1:0] o_status,
    input logic [7:0] o_run_pid,
    input logic       o_finished
);

    `ASSERT_CLK_RST(a_res_when_free, i_clk, i_rst_n, o_result_valid |-> !o_busy, "result strobed while busy")
    `ASSERT_CLK_RST(a_accept_busy, i_clk, i_rst_n, (i_start && !o_busy) |=> o_busy, "accepted transaction did not raise busy")
    `ASSERT_CLK_RST(a_busy_ends_res, i_clk, i_rst_n, $fell(o_busy) |-> o_result_valid, "busy dropped without a result")
    `ASSERT_CLK_RST(a_no_run_fields, i_clk, i_rst_n, (o_result_valid && (o_status != ST_RAN)) |-> ((o_run_pid == 8'd0) && !o_finished), "pid or finished set on a non-run result")
    `ASSERT_CLK(a_one_strobe, i_clk, o_result_valid |=> !o_result_valid, "result strobe longer than one cycle")

endmodule

bind process_slot_scheduler pss_chk u_pss_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_result_valid (o_result_valid),
    .o_status       (o_status),
    .o_run_pid      (o_run_pid),
    .o_finished     (o_finished)
);
